[hw/rtl/xylm_pkg.sv]
package xylm_pkg;

  // Lattice geometry: the side is a power of two so that neighbours wrap by plain
  // modular bit arithmetic on the row and column fields.
  localparam int SIDE_BITS      = 6;
  localparam int SIDE           = 1 << SIDE_BITS;
  localparam int SITE_W         = 2 * SIDE_BITS;
  localparam int SITES          = 1 << SITE_W;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

  localparam int ACTION_W       = 2;
  localparam int IN_SITE_W      = 12;
  localparam int IN_ANGLE_W     = 16;
  localparam int BETA_W         = 16;
  localparam int E_W            = 30;
  localparam int H_W            = 29;
  localparam int M_W            = 29;
  localparam int P_W            = 17;

  localparam int ACC_W          = SITE_W + TRIG_FRAC_BITS + 4;
  localparam int DE_W           = TRIG_FRAC_BITS + 5;

  localparam logic [BETA_W-1:0] BETA_RESET = 16'd256;

  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EVAL    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MEASURE = 2'd2;

  // Operand codes; the first five double as neighbour codes for spin reads.
  localparam logic [2:0] OP_SELF = 3'd0;
  localparam logic [2:0] OP_R    = 3'd1;
  localparam logic [2:0] OP_L    = 3'd2;
  localparam logic [2:0] OP_D    = 3'd3;
  localparam logic [2:0] OP_U    = 3'd4;
  localparam logic [2:0] OP_NEW  = 3'd5;
  localparam logic [2:0] OP_ZERO = 3'd6;

  localparam logic [1:0] DST_E  = 2'd0;
  localparam logic [1:0] DST_H  = 2'd1;
  localparam logic [1:0] DST_MX = 2'd2;
  localparam logic [1:0] DST_MY = 2'd3;

  localparam int TERM_W = 5;
  localparam logic [TERM_W-1:0] EVAL_FIRST = 5'd0;
  localparam logic [TERM_W-1:0] EVAL_LAST  = 5'd15;
  localparam logic [TERM_W-1:0] MEAS_FIRST = 5'd16;
  localparam logic [TERM_W-1:0] MEAS_LAST  = 5'd20;

  localparam logic [30:0] ONE30 = 31'd1073741824;
  localparam logic [30:0] SC1   = 31'd1686629713;
  localparam logic [30:0] SC3   = 31'd693598668;
  localparam logic [30:0] SC5   = 31'd85569306;
  localparam logic [30:0] SC7   = 31'd5026995;
  localparam logic [30:0] SC9   = 31'd172273;
  localparam logic [16:0] INV_LN2_Q16 = 17'd94548;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [P_W-1:0] PROB_ONE = 17'd65536;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic       cosine;
    logic       negate;
    logic [1:0] dest;
  } term_t;

  typedef struct packed {
    logic              clr_we;
    logic [SITE_W-1:0] clr_addr;
    logic              item_wr;
    logic              item_load;
    logic              rd_en;
    logic [2:0]        rd_nb;
    logic              capture;
    logic              scan_mode;
    logic [SITE_W-1:0] scan_site;
    logic              term_start;
    logic [TERM_W-1:0] term_idx;
    logic              exp_start;
    logic              out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic trig_done;
    logic exp_done;
    logic out_busy;
  } ctl_status_t;

  // One trig term: sign, function, operand pair of the phase (a - b) and destination accumulator.
  function automatic term_t term_of(input logic [TERM_W-1:0] idx);
    term_t tm;
    tm = '{a_sel: OP_ZERO, b_sel: OP_ZERO, cosine: 1'b0, negate: 1'b0, dest: DST_E};
    unique case (idx)
      5'd0:  tm = '{OP_SELF, OP_R,    1'b1, 1'b0, DST_E};
      5'd1:  tm = '{OP_NEW,  OP_R,    1'b1, 1'b1, DST_E};
      5'd2:  tm = '{OP_SELF, OP_L,    1'b1, 1'b0, DST_E};
      5'd3:  tm = '{OP_NEW,  OP_L,    1'b1, 1'b1, DST_E};
      5'd4:  tm = '{OP_SELF, OP_D,    1'b1, 1'b0, DST_E};
      5'd5:  tm = '{OP_NEW,  OP_D,    1'b1, 1'b1, DST_E};
      5'd6:  tm = '{OP_SELF, OP_U,    1'b1, 1'b0, DST_E};
      5'd7:  tm = '{OP_NEW,  OP_U,    1'b1, 1'b1, DST_E};
      5'd8:  tm = '{OP_L,    OP_NEW,  1'b0, 1'b0, DST_H};
      5'd9:  tm = '{OP_NEW,  OP_R,    1'b0, 1'b0, DST_H};
      5'd10: tm = '{OP_L,    OP_SELF, 1'b0, 1'b1, DST_H};
      5'd11: tm = '{OP_SELF, OP_R,    1'b0, 1'b1, DST_H};
      5'd12: tm = '{OP_NEW,  OP_ZERO, 1'b1, 1'b0, DST_MX};
      5'd13: tm = '{OP_SELF, OP_ZERO, 1'b1, 1'b1, DST_MX};
      5'd14: tm = '{OP_NEW,  OP_ZERO, 1'b0, 1'b0, DST_MY};
      5'd15: tm = '{OP_SELF, OP_ZERO, 1'b0, 1'b1, DST_MY};
      5'd16: tm = '{OP_SELF, OP_R,    1'b1, 1'b1, DST_E};
      5'd17: tm = '{OP_SELF, OP_D,    1'b1, 1'b1, DST_E};
      5'd18: tm = '{OP_SELF, OP_R,    1'b0, 1'b0, DST_H};
      5'd19: tm = '{OP_SELF, OP_ZERO, 1'b1, 1'b0, DST_MX};
      5'd20: tm = '{OP_SELF, OP_ZERO, 1'b0, 1'b0, DST_MY};
      default: tm = '{OP_ZERO, OP_ZERO, 1'b0, 1'b0, DST_E};
    endcase
    return tm;
  endfunction

  // floor(2^32 / k) for the Horner divisors of the exponential.
  function automatic logic [32:0] recip(input logic [2:0] k);
    logic [32:0] m;
    unique case (k)
      3'd1:    m = 33'h1_0000_0000;
      3'd2:    m = 33'd2147483648;
      3'd3:    m = 33'd1431655765;
      3'd4:    m = 33'd1073741824;
      3'd5:    m = 33'd858993459;
      3'd6:    m = 33'd715827882;
      3'd7:    m = 33'd613566756;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                  input int w);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = signed'((ACC_W'(1) << (w - 1)) - ACC_W'(1));
    lo = -hi - signed'(ACC_W'(1));
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

[hw/rtl/xy_lattice_metropolis_engine.sv]
// The time from the accepting edge to the loaded result is set by the spin reads, by one
// sine unit taking the trig terms one at a time and, for an evaluate, by the exp unit.
// A measure runs over all 4096 sites.
// Throughput: one transaction in flight; the next input is taken the cycle after the result
// is loaded. Reset sweeps the store to zero with the input stalled and sets beta to 256.
module xy_lattice_metropolis_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [xylm_pkg::ACTION_W-1:0]          action,
  input  logic [xylm_pkg::IN_SITE_W-1:0]         site,
  input  logic [xylm_pkg::IN_ANGLE_W-1:0]        angle,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [xylm_pkg::E_W-1:0]        energy_value,
  output logic signed [xylm_pkg::H_W-1:0]        helicity_value,
  output logic signed [xylm_pkg::M_W-1:0]        magnet_x,
  output logic signed [xylm_pkg::M_W-1:0]        magnet_y,
  output logic [xylm_pkg::P_W-1:0]               accept_prob,
  input  logic                                   cfg_we,
  input  logic [xylm_pkg::BETA_W-1:0]            cfg_wdata
);

  // The controller sequences each transaction: spin reads from the lattice store,
  // one trig term at a time through the sine unit, the acceptance exponential for
  // an evaluate, and finally the load of the output register. The datapath owns
  // the store, the operand registers, the four accumulators and the output stage.
  xylm_pkg::ctl_cmd_t    cmd;
  xylm_pkg::ctl_status_t status;

  xylm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .action  (action),
    .in_stall(in_stall),
    .cmd     (cmd),
    .status  (status)
  );

  xylm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .site          (site),
    .angle         (angle),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .energy_value  (energy_value),
    .helicity_value(helicity_value),
    .magnet_x      (magnet_x),
    .magnet_y      (magnet_y),
    .accept_prob   (accept_prob)
  );

endmodule

[hw/rtl/xylm_ram.sv]
module xylm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/xylm_trig.sv]
module xylm_trig (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [xylm_pkg::ANGLE_BITS-1:0]        phase,
  output logic                                   done,
  output logic signed [xylm_pkg::TRIG_W-1:0]     value
);

  // Sine by quadrant folding and an odd Horner polynomial, one product a cycle.
  localparam logic [2:0] TS_SQ  = 3'd1;
  localparam logic [2:0] TS_H7  = 3'd2;
  localparam logic [2:0] TS_H5  = 3'd3;
  localparam logic [2:0] TS_H3  = 3'd4;
  localparam logic [2:0] TS_H1  = 3'd5;
  localparam logic [2:0] TS_OUT = 3'd6;
  localparam int FRAC_W = xylm_pkg::ANGLE_BITS - 2;
  localparam int TF     = xylm_pkg::TRIG_FRAC_BITS;

  logic        busy;
  logic [2:0]  step;
  logic [1:0]  quad;
  logic [30:0] x;
  logic [30:0] x2;
  logic [30:0] t;
  logic [30:0] ma;
  logic [30:0] mb;
  logic [61:0] prod;
  logic [30:0] prod_sh;
  logic [30:0] coef;
  logic [30:0] x_init;
  logic [31:0] rnd;
  logic [xylm_pkg::TRIG_W-1:0] mag;
  logic [xylm_pkg::TRIG_W-1:0] mag_lim;

  always_comb begin
    x_init = 31'(phase[FRAC_W-1:0]) << (30 - FRAC_W);
    if (phase[FRAC_W]) begin
      x_init = xylm_pkg::ONE30 - x_init;
    end
    unique case (step)
      TS_SQ:   begin ma = x;  mb = x; end
      TS_OUT:  begin ma = x;  mb = t; end
      default: begin ma = x2; mb = t; end
    endcase
    unique case (step)
      TS_H7:   coef = xylm_pkg::SC7;
      TS_H5:   coef = xylm_pkg::SC5;
      TS_H3:   coef = xylm_pkg::SC3;
      default: coef = xylm_pkg::SC1;
    endcase
    prod    = 62'(ma) * 62'(mb);
    prod_sh = prod[60:30];
    rnd     = 32'(prod_sh) + (32'd1 << (29 - TF));
    mag     = rnd[31:30-TF];
    mag_lim = (mag > (xylm_pkg::TRIG_W'(1) << TF)) ? (xylm_pkg::TRIG_W'(1) << TF) : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= TS_SQ;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= TS_SQ;
        quad <= phase[xylm_pkg::ANGLE_BITS-1:xylm_pkg::ANGLE_BITS-2];
        x    <= x_init;
        t    <= xylm_pkg::SC9;
      end else if (busy) begin
        step <= step + 3'd1;
        unique case (step)
          TS_SQ:  x2 <= prod_sh;
          TS_OUT: begin
            value <= quad[1] ? -signed'(mag_lim) : signed'(mag_lim);
            done  <= 1'b1;
            busy  <= 1'b0;
          end
          default: t <= coef - prod_sh;
        endcase
      end
    end
  end

endmodule

[hw/rtl/xylm_exp.sv]
module xylm_exp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [xylm_pkg::DE_W-1:0]     de,
  input  logic [xylm_pkg::BETA_W-1:0]          beta,
  output logic                                 done,
  output logic [xylm_pkg::P_W-1:0]             prob
);

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_LOG   = 3'd1;
  localparam logic [2:0] E_FRAC  = 3'd2;
  localparam logic [2:0] E_MUL   = 3'd3;
  localparam logic [2:0] E_RECIP = 3'd4;
  localparam logic [2:0] E_CORR  = 3'd5;
  localparam logic [2:0] E_FINAL = 3'd6;

  localparam int XW = xylm_pkg::DE_W - 1 + xylm_pkg::BETA_W;
  localparam int SH = xylm_pkg::TRIG_FRAC_BITS - 8;
  localparam int XS = XW - SH;
  localparam int YW = XS + 17 - 16;

  logic [2:0]    state;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [XS+16:0] y_full;
  logic [YW-17:0] n;
  logic [4:0]    nsh;
  logic [29:0]   t;
  logic [45:0]   t_full;
  logic [30:0]   u;
  logic [2:0]    k;
  logic [60:0]   prod;
  logic [30:0]   p;
  logic [63:0]   pm;
  logic [31:0]   q0;
  logic [33:0]   rem;
  logic [31:0]   q;
  logic [31:0]   fsum;
  logic [31:0]   fres;

  always_comb begin
    y_full = (XS+17)'(x[XW-1:SH]) * (XS+17)'(xylm_pkg::INV_LN2_Q16);
    n      = y[YW-1:16];
    t_full = 46'(y[15:0]) * 46'(xylm_pkg::LN2_Q30);
    q0     = pm[63:32];
    rem    = 34'(p) - 34'(q0) * 34'(k);
    q      = (rem >= 34'(k)) ? q0 + 32'd1 : q0;
    fsum   = 32'(u) + (32'd1 << (5'd13 + nsh));
    fres   = fsum >> (5'd14 + nsh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            if (de[xylm_pkg::DE_W-1] || (de == '0)) begin
              prob <= xylm_pkg::PROB_ONE;
              done <= 1'b1;
            end else begin
              x     <= XW'(de[xylm_pkg::DE_W-2:0]) * XW'(beta);
              state <= E_LOG;
            end
          end
        end
        E_LOG: begin
          y     <= y_full[XS+16:16];
          state <= E_FRAC;
        end
        E_FRAC: begin
          if (n > (YW-16)'(16)) begin
            prob  <= '0;
            done  <= 1'b1;
            state <= E_IDLE;
          end else begin
            nsh   <= n[4:0];
            t     <= t_full[45:16];
            u     <= xylm_pkg::ONE30;
            k     <= 3'd7;
            state <= E_MUL;
          end
        end
        E_MUL: begin
          prod  <= 61'(t) * 61'(u);
          state <= E_RECIP;
        end
        E_RECIP: begin
          p     <= prod[60:30];
          pm    <= 64'(prod[60:30]) * 64'(xylm_pkg::recip(k));
          state <= E_CORR;
        end
        E_CORR: begin
          u <= xylm_pkg::ONE30 - q[30:0];
          if (k == 3'd1) begin
            state <= E_FINAL;
          end else begin
            k     <= k - 3'd1;
            state <= E_MUL;
          end
        end
        E_FINAL: begin
          prob  <= (fres > 32'd65536) ? xylm_pkg::PROB_ONE : fres[xylm_pkg::P_W-1:0];
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/xylm_ctrl.sv]
module xylm_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [xylm_pkg::ACTION_W-1:0]     action,
  output logic                              in_stall,
  output xylm_pkg::ctl_cmd_t                cmd,
  input  xylm_pkg::ctl_status_t             status
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_LATCH = 4'd3;
  localparam logic [3:0] S_TERM  = 4'd4;
  localparam logic [3:0] S_TWAIT = 4'd5;
  localparam logic [3:0] S_EXP   = 4'd6;
  localparam logic [3:0] S_EWAIT = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [xylm_pkg::SITE_W-1:0] LAST_SITE = '1;

  logic [3:0]                    state;
  logic [3:0]                    state_next;
  logic [xylm_pkg::SITE_W-1:0]   clr_cnt;
  logic [xylm_pkg::SITE_W-1:0]   scan;
  logic [2:0]                    rd_idx;
  logic [xylm_pkg::TERM_W-1:0]   term_idx;
  logic                          is_meas;
  logic                          last_read;
  logic                          last_term;

  assign in_stall  = (state != S_IDLE);
  assign last_read = is_meas ? (rd_idx == xylm_pkg::OP_D) : (rd_idx == xylm_pkg::OP_U);
  assign last_term = is_meas ? (term_idx == xylm_pkg::MEAS_LAST)
                             : (term_idx == xylm_pkg::EVAL_LAST);

  always_comb begin
    cmd            = '0;
    cmd.clr_addr   = clr_cnt;
    cmd.rd_nb      = rd_idx;
    cmd.scan_mode  = is_meas;
    cmd.scan_site  = scan;
    cmd.term_idx   = term_idx;
    state_next     = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (clr_cnt == LAST_SITE) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          cmd.item_wr   = (action == xylm_pkg::ACT_WRITE);
          if ((action == xylm_pkg::ACT_EVAL) || (action == xylm_pkg::ACT_MEASURE)) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.capture = 1'b1;
        state_next  = last_read ? S_TERM : S_READ;
      end
      S_TERM: begin
        cmd.term_start = 1'b1;
        state_next     = S_TWAIT;
      end
      S_TWAIT: begin
        if (status.trig_done) begin
          if (!last_term) begin
            state_next = S_TERM;
          end else if (is_meas) begin
            state_next = S_NEXT;
          end else begin
            state_next = S_EXP;
          end
        end
      end
      S_EXP: begin
        cmd.exp_start = 1'b1;
        state_next    = S_EWAIT;
      end
      S_EWAIT: begin
        if (status.exp_done) begin
          state_next = S_DONE;
        end
      end
      S_NEXT: begin
        state_next = (scan == LAST_SITE) ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      scan     <= '0;
      rd_idx   <= xylm_pkg::OP_SELF;
      term_idx <= xylm_pkg::EVAL_FIRST;
      is_meas  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + xylm_pkg::SITE_W'(1);
      end
      if (cmd.item_load) begin
        is_meas  <= (action == xylm_pkg::ACT_MEASURE);
        scan     <= '0;
        rd_idx   <= xylm_pkg::OP_SELF;
      end
      if (state == S_LATCH) begin
        if (last_read) begin
          rd_idx   <= xylm_pkg::OP_SELF;
          term_idx <= is_meas ? xylm_pkg::MEAS_FIRST : xylm_pkg::EVAL_FIRST;
        end else if (is_meas && (rd_idx == xylm_pkg::OP_R)) begin
          rd_idx <= xylm_pkg::OP_D;
        end else begin
          rd_idx <= rd_idx + 3'd1;
        end
      end
      if ((state == S_TWAIT) && status.trig_done && !last_term) begin
        term_idx <= term_idx + xylm_pkg::TERM_W'(1);
      end
      if ((state == S_NEXT) && (scan != LAST_SITE)) begin
        scan <= scan + xylm_pkg::SITE_W'(1);
      end
    end
  end

endmodule

[hw/rtl/xylm_datapath.sv]
module xylm_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  xylm_pkg::ctl_cmd_t                     cmd,
  output xylm_pkg::ctl_status_t                  status,
  input  logic [xylm_pkg::IN_SITE_W-1:0]         site,
  input  logic [xylm_pkg::IN_ANGLE_W-1:0]        angle,
  input  logic                                   cfg_we,
  input  logic [xylm_pkg::BETA_W-1:0]            cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [xylm_pkg::E_W-1:0]        energy_value,
  output logic signed [xylm_pkg::H_W-1:0]        helicity_value,
  output logic signed [xylm_pkg::M_W-1:0]        magnet_x,
  output logic signed [xylm_pkg::M_W-1:0]        magnet_y,
  output logic [xylm_pkg::P_W-1:0]               accept_prob
);

  localparam int SB = xylm_pkg::SIDE_BITS;
  localparam int SW = xylm_pkg::SITE_W;
  localparam int AB = xylm_pkg::ANGLE_BITS;
  localparam int AW = xylm_pkg::ACC_W;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  logic [xylm_pkg::BETA_W-1:0] beta;
  logic [SW-1:0]    site_reg;
  logic [AB-1:0]    new_ang;
  logic [AB-1:0]    s_self;
  logic [AB-1:0]    s_r;
  logic [AB-1:0]    s_l;
  logic [AB-1:0]    s_d;
  logic [AB-1:0]    s_u;
  logic signed [AW-1:0] acc_e;
  logic signed [AW-1:0] acc_h;
  logic signed [AW-1:0] acc_mx;
  logic signed [AW-1:0] acc_my;
  logic [xylm_pkg::P_W-1:0] prob_reg;

  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  logic [AB-1:0]    mem_wdata;
  logic [SW-1:0]    mem_raddr;
  logic [AB-1:0]    mem_rdata;
  logic [SW-1:0]    base;
  logic [SB-1:0]    row;
  logic [SB-1:0]    col;

  xylm_pkg::term_t  term;
  logic [AB-1:0]    op_a;
  logic [AB-1:0]    op_b;
  logic [AB-1:0]    phase;
  logic             trig_done;
  logic signed [xylm_pkg::TRIG_W-1:0] trig_val;
  logic signed [AW-1:0] trig_ext;
  logic             exp_done;
  logic [xylm_pkg::P_W-1:0] exp_prob;
  logic signed [AW-1:0] sat_e;
  logic signed [AW-1:0] sat_h;
  logic signed [AW-1:0] sat_mx;
  logic signed [AW-1:0] sat_my;

  function automatic logic [AB-1:0] pick(input logic [2:0] sel, input logic [AB-1:0] so,
                                         input logic [AB-1:0] sr, input logic [AB-1:0] sl,
                                         input logic [AB-1:0] sd, input logic [AB-1:0] su,
                                         input logic [AB-1:0] sn);
    logic [AB-1:0] v;
    unique case (sel)
      xylm_pkg::OP_SELF: v = so;
      xylm_pkg::OP_R:    v = sr;
      xylm_pkg::OP_L:    v = sl;
      xylm_pkg::OP_D:    v = sd;
      xylm_pkg::OP_U:    v = su;
      xylm_pkg::OP_NEW:  v = sn;
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    mem_we    = cmd.clr_we || cmd.item_wr;
    mem_waddr = cmd.clr_we ? cmd.clr_addr : site[SW-1:0];
    mem_wdata = cmd.clr_we ? '0 : angle[AB-1:0];

    base = cmd.scan_mode ? cmd.scan_site : site_reg;
    row  = base[SW-1:SB];
    col  = base[SB-1:0];
    unique case (cmd.rd_nb)
      xylm_pkg::OP_R: mem_raddr = {row, col + SB'(1)};
      xylm_pkg::OP_L: mem_raddr = {row, col - SB'(1)};
      xylm_pkg::OP_D: mem_raddr = {row + SB'(1), col};
      xylm_pkg::OP_U: mem_raddr = {row - SB'(1), col};
      default:        mem_raddr = base;
    endcase

    term  = xylm_pkg::term_of(cmd.term_idx);
    op_a  = pick(term.a_sel, s_self, s_r, s_l, s_d, s_u, new_ang);
    op_b  = pick(term.b_sel, s_self, s_r, s_l, s_d, s_u, new_ang);
    phase = op_a - op_b + (term.cosine ? QUARTER : AB'(0));
    trig_ext = AW'(trig_val);
    if (term.negate) begin
      trig_ext = -trig_ext;
    end

    sat_e  = xylm_pkg::sat(acc_e,  xylm_pkg::E_W);
    sat_h  = xylm_pkg::sat(acc_h,  xylm_pkg::H_W);
    sat_mx = xylm_pkg::sat(acc_mx, xylm_pkg::M_W);
    sat_my = xylm_pkg::sat(acc_my, xylm_pkg::M_W);

    status.trig_done = trig_done;
    status.exp_done  = exp_done;
    status.out_busy  = out_valid && out_stall;
  end

  xylm_ram #(
    .WIDTH(AB),
    .DEPTH(xylm_pkg::SITES)
  ) u_spins (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (cmd.rd_en),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  xylm_trig u_trig (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.term_start),
    .phase(phase),
    .done (trig_done),
    .value(trig_val)
  );

  xylm_exp u_exp (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.exp_start),
    .de   (acc_e[xylm_pkg::DE_W-1:0]),
    .beta (beta),
    .done (exp_done),
    .prob (exp_prob)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      beta      <= xylm_pkg::BETA_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        beta <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      site_reg <= site[SW-1:0];
      new_ang  <= angle[AB-1:0];
      acc_e    <= '0;
      acc_h    <= '0;
      acc_mx   <= '0;
      acc_my   <= '0;
      prob_reg <= '0;
    end
    if (cmd.capture) begin
      unique case (cmd.rd_nb)
        xylm_pkg::OP_R: s_r    <= mem_rdata;
        xylm_pkg::OP_L: s_l    <= mem_rdata;
        xylm_pkg::OP_D: s_d    <= mem_rdata;
        xylm_pkg::OP_U: s_u    <= mem_rdata;
        default:        s_self <= mem_rdata;
      endcase
    end
    if (trig_done) begin
      unique case (term.dest)
        xylm_pkg::DST_E:  acc_e  <= acc_e  + trig_ext;
        xylm_pkg::DST_H:  acc_h  <= acc_h  + trig_ext;
        xylm_pkg::DST_MX: acc_mx <= acc_mx + trig_ext;
        default:          acc_my <= acc_my + trig_ext;
      endcase
    end
    if (exp_done) begin
      prob_reg <= exp_prob;
    end
    if (cmd.out_load) begin
      energy_value   <= sat_e[xylm_pkg::E_W-1:0];
      helicity_value <= sat_h[xylm_pkg::H_W-1:0];
      magnet_x       <= sat_mx[xylm_pkg::M_W-1:0];
      magnet_y       <= sat_my[xylm_pkg::M_W-1:0];
      accept_prob    <= prob_reg;
    end
  end

endmodule

[hw/rtl/xylm_checker.sv]
module xylm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [xylm_pkg::E_W-1:0] energy_value,
  input logic [xylm_pkg::P_W-1:0]        accept_prob
);

  // The clearing sweep follows every reset, so the input stays stalled.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(energy_value))
    else $error("stalled result dropped or changed");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accept_prob <= xylm_pkg::PROB_ONE))
    else $error("acceptance above one");

  // One transaction at a time: once an input is taken the next one is held off.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second input taken while one is in flight");

endmodule

bind xy_lattice_metropolis_engine xylm_checker u_xylm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .energy_value(energy_value),
  .accept_prob (accept_prob)
);

[bench/xy_lattice_metropolis_engine_tb.sv]
module xy_lattice_metropolis_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xylm_pkg::*;

  // One input transaction as the sender sees it.
  typedef struct {
    logic [ACTION_W-1:0]   act;
    logic [IN_SITE_W-1:0]  st;
    logic [IN_ANGLE_W-1:0] ang;
  } lattice_item_t;

  // One result transaction, held at the block's own field widths.
  typedef struct {
    logic signed [E_W-1:0] energy;
    logic signed [H_W-1:0] helicity;
    logic signed [M_W-1:0] mx;
    logic signed [M_W-1:0] my;
    logic [P_W-1:0]        prob;
  } lattice_reading_t;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  // The action code that the block leaves unused.
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACTION_W-1:0]     action = '0;
  logic [IN_SITE_W-1:0]    site = '0;
  logic [IN_ANGLE_W-1:0]   angle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [E_W-1:0]   energy_value;
  logic signed [H_W-1:0]   helicity_value;
  logic signed [M_W-1:0]   magnet_x;
  logic signed [M_W-1:0]   magnet_y;
  logic [P_W-1:0]          accept_prob;
  logic                    cfg_we = 1'b0;
  logic [BETA_W-1:0]       cfg_wdata = '0;

  xy_lattice_metropolis_engine u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .site           (site),
    .angle          (angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .energy_value   (energy_value),
    .helicity_value (helicity_value),
    .magnet_x       (magnet_x),
    .magnet_y       (magnet_y),
    .accept_prob    (accept_prob),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // The bench's own copy of the lattice, advanced at each accepted transaction, and of beta.
  logic [ANGLE_BITS-1:0] lattice_copy [SITES];
  logic [BETA_W-1:0]     beta_copy = BETA_RESET;

  // A shadow of the lattice as the stimulus will leave it, so that generated proposals
  // can sit close to the stored angle and give small positive energy changes.
  logic [ANGLE_BITS-1:0] planned_spin [SITES];

  lattice_item_t    pending_items[$];
  lattice_reading_t awaited_readings[$];
  lattice_item_t    offered_item;
  int               send_gap = 0;
  int               stall_left = 0;
  bit               quiet_tail = 1'b0;
  int               error_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20ns * 6_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Sine in Q15 by quadrant folding and the odd Taylor series in Q30.
  function automatic longint lattice_sin(input logic [ANGLE_BITS-1:0] ph);
    logic [1:0]      quad;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    quad = ph[ANGLE_BITS-1 -: 2];
    x = longint'(ph[ANGLE_BITS-3:0]) << (30 - (ANGLE_BITS - 2));
    if (quad[0]) begin
      x = Q30_ONE - x;
    end
    x2 = (x * x) >> 30;
    t = 64'd172273;
    t = 64'd5026995 - ((x2 * t) >> 30);
    t = 64'd85569306 - ((x2 * t) >> 30);
    t = 64'd693598668 - ((x2 * t) >> 30);
    t = 64'd1686629713 - ((x2 * t) >> 30);
    s = (x * t) >> 30;
    s = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    if (s > (64'd1 << TRIG_FRAC_BITS)) begin
      s = 64'd1 << TRIG_FRAC_BITS;
    end
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint lattice_cos(input logic [ANGLE_BITS-1:0] ph);
    logic [ANGLE_BITS-1:0] shifted;
    shifted = ph + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    return lattice_sin(shifted);
  endfunction

  function automatic longint clamp_width(input longint v, input int w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v > lim - 1) begin
      return lim - 1;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // Metropolis acceptance min(1, exp(-beta*dE)) in Q1.16.
  function automatic longint unsigned metropolis_accept(input longint de);
    longint unsigned x;
    longint unsigned y;
    longint unsigned n;
    longint unsigned t;
    longint unsigned u;
    longint unsigned r;
    if (de <= 0) begin
      return 64'd65536;
    end
    x = (longint'(de) * longint'(beta_copy)) >> (TRIG_FRAC_BITS - 8);
    y = (x * 64'd94548) >> 16;
    n = y >> 16;
    if (n > 16) begin
      return 64'd0;
    end
    t = ((y & 64'hFFFF) * 64'd744261118) >> 16;
    u = Q30_ONE;
    for (int k = 7; k >= 1; k--) begin
      u = Q30_ONE - (((t * u) >> 30) / k);
    end
    r = (u + (64'd1 << (13 + n))) >> (14 + n);
    return (r > 64'd65536) ? 64'd65536 : r;
  endfunction

  function automatic logic [SITE_W-1:0] neighbour(input logic [SITE_W-1:0] s,
                                                  input int drow, input int dcol);
    logic [SIDE_BITS-1:0] row;
    logic [SIDE_BITS-1:0] col;
    row = SIDE_BITS'(int'(s[SITE_W-1:SIDE_BITS]) + drow);
    col = SIDE_BITS'(int'(s[SIDE_BITS-1:0]) + dcol);
    return {row, col};
  endfunction

  // Works out the reading that one accepted transaction must produce, and applies
  // its effect on the lattice copy.
  function automatic lattice_reading_t lattice_response(input lattice_item_t it);
    lattice_reading_t      rd;
    longint                e;
    longint                h;
    longint                mx;
    longint                my;
    longint unsigned       acc;
    logic [SITE_W-1:0]     s;
    logic [ANGLE_BITS-1:0] old;
    logic [ANGLE_BITS-1:0] nw;
    logic [ANGLE_BITS-1:0] r;
    logic [ANGLE_BITS-1:0] l;
    logic [ANGLE_BITS-1:0] d;
    logic [ANGLE_BITS-1:0] u;
    logic [ANGLE_BITS-1:0] nb [4];
    e = 0;
    h = 0;
    mx = 0;
    my = 0;
    acc = 0;
    s = it.st;
    nw = it.ang;
    case (it.act)
      ACT_WRITE: begin
        lattice_copy[s] = nw;
      end
      ACT_EVAL: begin
        old = lattice_copy[s];
        r = lattice_copy[neighbour(s, 0, 1)];
        l = lattice_copy[neighbour(s, 0, -1)];
        d = lattice_copy[neighbour(s, 1, 0)];
        u = lattice_copy[neighbour(s, -1, 0)];
        nb = '{r, l, d, u};
        for (int k = 0; k < 4; k++) begin
          e += lattice_cos(old - nb[k]) - lattice_cos(nw - nb[k]);
        end
        h = lattice_sin(l - nw) + lattice_sin(nw - r) - lattice_sin(l - old)
          - lattice_sin(old - r);
        mx = lattice_cos(nw) - lattice_cos(old);
        my = lattice_sin(nw) - lattice_sin(old);
        acc = metropolis_accept(e);
      end
      ACT_MEASURE: begin
        for (int i = 0; i < SITES; i++) begin
          old = lattice_copy[i];
          r = lattice_copy[neighbour(SITE_W'(i), 0, 1)];
          d = lattice_copy[neighbour(SITE_W'(i), 1, 0)];
          e -= lattice_cos(old - r) + lattice_cos(old - d);
          h += lattice_sin(old - r);
          mx += lattice_cos(old);
          my += lattice_sin(old);
        end
      end
      default: begin
      end
    endcase
    rd.energy   = E_W'(clamp_width(e, E_W));
    rd.helicity = H_W'(clamp_width(h, H_W));
    rd.mx       = M_W'(clamp_width(mx, M_W));
    rd.my       = M_W'(clamp_width(my, M_W));
    rd.prob     = acc[P_W-1:0];
    return rd;
  endfunction

  // Driver: a new transaction is offered only when the previous one has been taken
  // or none is offered, so a stalled payload never changes and valid never looks at
  // stall. Prediction happens at the edge that accepts the transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_readings.push_back(lattice_response(offered_item));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          offered_item = pending_items.pop_front();
          action   <= offered_item.act;
          site     <= offered_item.st;
          angle    <= offered_item.ang;
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            send_gap <= $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endfunction

  // Monitor: compares every accepted result with the oldest awaited reading and
  // drives the receiver's stall in random bursts.
  always @(posedge clk) begin
    lattice_reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual energy %0d", $realtime,
                 energy_value);
        error_count++;
      end else begin
        want = awaited_readings.pop_front();
        check_field("energy_value", want.energy, energy_value);
        check_field("helicity_value", want.helicity, helicity_value);
        check_field("magnet_x", want.mx, magnet_x);
        check_field("magnet_y", want.my, magnet_y);
        check_field("accept_prob", want.prob, accept_prob);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_item(input logic [ACTION_W-1:0] a, input int s, input int ang);
    lattice_item_t it;
    it.act = a;
    it.st  = IN_SITE_W'(s);
    it.ang = IN_ANGLE_W'(ang);
    if (a == ACT_WRITE) begin
      planned_spin[it.st] = it.ang;
    end
    pending_items.push_back(it);
  endtask

  // Mostly evaluates and writes, half of them in a small patch so neighbours are populated,
  // proposals often near the stored angle; now and then the unused action code.
  task automatic queue_random(input int count);
    int                    s;
    int                    pick;
    logic [ANGLE_BITS-1:0] ang;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, SITES - 1))
                                      : int'({6'($urandom_range(0, 7)),
                                              6'($urandom_range(0, 7))});
      s = s ^ ($urandom_range(0, 9) == 0 ? 32'hFC0 : 32'h000);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) begin
        ang = ANGLE_BITS'($urandom);
      end else begin
        ang = planned_spin[s] + 16'($urandom_range(0, 1200)) - 16'd600;
      end
      if (pick < 40) begin
        queue_item(ACT_WRITE, s, int'(ang));
      end else if (pick < 96) begin
        queue_item(ACT_EVAL, s, int'(ang));
      end else begin
        queue_item(ACT_SPARE, s, int'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || awaited_readings.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // beta changes only while the block is idle; the bench copy follows at once.
  task automatic set_beta(input logic [BETA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    beta_copy = v;
  endtask

  initial begin
    int corners [4];
    corners = '{0, SIDE - 1, SITES - SIDE, SITES - 1};
    for (int i = 0; i < SITES; i++) begin
      lattice_copy[i] = '0;
      planned_spin[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset value of beta: an unchanged proposal on the cleared
    // lattice, a half-turn proposal, writes at the wrapping corners with the extreme
    // angles, evaluates there, the unused action code and one whole-lattice measure.
    queue_item(ACT_EVAL, 0, 0);
    queue_item(ACT_EVAL, 0, 16'h8000);
    queue_item(ACT_EVAL, SITES - 1, 16'hFFFF);
    foreach (corners[k]) begin
      queue_item(ACT_WRITE, corners[k], (k == 0) ? 16'hFFFF : k * 16384);
    end
    queue_item(ACT_WRITE, 1, 16'h0001);
    queue_item(ACT_WRITE, SIDE, 16'h7FFF);
    foreach (corners[k]) begin
      queue_item(ACT_EVAL, corners[k], 16'h8000 + k);
    end
    queue_item(ACT_EVAL, 0, 16'hFFF0);
    queue_item(ACT_EVAL, SIDE + 1, 16'h0000);
    queue_item(ACT_SPARE, 12'hFFF, 16'hFFFF);
    queue_item(ACT_WRITE, 12'hAAA, 16'h5555);
    queue_item(ACT_EVAL, 12'h555, 16'hAAAA);
    queue_item(ACT_MEASURE, 12'hFFF, 16'hFFFF);
    wait_drained();

    // Smallest beta gives acceptances near one for moderate energy rises.
    set_beta(16'd1);
    queue_random(300);
    wait_drained();

    // Largest beta drives acceptance to zero for almost any rise.
    set_beta(16'hFFFF);
    queue_random(300);
    wait_drained();

    set_beta(16'($urandom_range(2, 1024)));
    queue_random(300);
    queue_item(ACT_MEASURE, int'($urandom), int'($urandom));
    wait_drained();

    // Last stretch: back to beta of one, with no idling on either side.
    set_beta(BETA_RESET);
    quiet_tail = 1'b1;
    queue_random(300);
    queue_item(ACT_MEASURE, 0, 0);
    wait_drained();
    repeat (20) @(posedge clk);

    if (error_count == 0 && awaited_readings.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
